[rtl/tlla_pkg.sv]
package tlla_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_HYP_DEF       = 16;
  localparam int OBS_LEN_COUNT_DEF = 32;

  // Fixed field widths
  localparam int BASE_W     = 2;
  localparam int BASE_COUNT = 4;
  localparam int OBS_W      = 5;
  localparam int HYP_IN_W   = 5;
  localparam int ENTRY_W    = 24;
  localparam int SUM_W      = 32;

  // Candidates scanned per group in the argmax tree
  localparam int GROUP_SIZE = 8;

  // Request kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_OBS   = 1'b1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Observation request handed to the accumulate stage
  typedef struct packed {
    logic start;  // observation accepted this cycle
    logic last;   // final observation of the set
    logic hit;    // observed length lies inside the table
  } obs_req_t;

  // Add a table entry to a running sum, clamp to the signed limits
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]   a,
    input logic signed [ENTRY_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

[rtl/tlla_table_mem.sv]
module tlla_table_mem #(
  parameter int MAX_HYP       = tlla_pkg::MAX_HYP_DEF,
  parameter int OBS_LEN_COUNT = tlla_pkg::OBS_LEN_COUNT_DEF
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [$clog2(tlla_pkg::BASE_COUNT*OBS_LEN_COUNT)-1:0] wr_addr,
  input  logic [$clog2(MAX_HYP+1)-1:0] wr_lane,
  input  logic [tlla_pkg::ENTRY_W-1:0] wr_data,
  input  logic rd_en,
  input  logic [$clog2(tlla_pkg::BASE_COUNT*OBS_LEN_COUNT)-1:0] rd_addr,
  output logic [MAX_HYP:0][tlla_pkg::ENTRY_W-1:0] rd_row
);
  import tlla_pkg::*;

  localparam int HYP_COUNT = MAX_HYP + 1;
  localparam int DEPTH     = BASE_COUNT * OBS_LEN_COUNT;

  // One row per (base, observed length), one lane per hypothesis
  logic [HYP_COUNT-1:0][ENTRY_W-1:0] mem [DEPTH];

  // Write a single lane, read a whole row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

[rtl/tlla_accum.sv]
module tlla_accum #(
  parameter int MAX_HYP = tlla_pkg::MAX_HYP_DEF
) (
  input  logic clk,
  input  logic rst,
  input  tlla_pkg::obs_req_t req,
  input  logic [MAX_HYP:0][tlla_pkg::ENTRY_W-1:0] row,
  input  logic snap_ready,
  output logic free,
  output logic snap_valid,
  output logic [MAX_HYP:0][tlla_pkg::SUM_W-1:0] snap_sums
);
  import tlla_pkg::*;

  localparam int HYP_COUNT = MAX_HYP + 1;

  logic s1_valid;
  logic s1_last;
  logic s1_hit;
  logic go;
  logic [HYP_COUNT-1:0][SUM_W-1:0] sums;
  logic [HYP_COUNT-1:0][SUM_W-1:0] sums_next;

  // Advance unless a last observation waits for the snapshot slot
  always_comb begin
    go         = s1_valid && (!s1_last || snap_ready);
    free       = !s1_valid || go;
    snap_valid = s1_valid && s1_last;
    for (int t = 0; t < HYP_COUNT; t++) begin
      sums_next[t] = s1_hit ? sat_add($signed(sums[t]), $signed(row[t])) : sums[t];
    end
    snap_sums = sums_next;
  end

  // Hold the request while stalled, clear the sums after a last observation
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s1_hit   <= 1'b0;
      sums     <= '0;
    end else begin
      if (free) begin
        s1_valid <= req.start;
        s1_last  <= req.last;
        s1_hit   <= req.hit;
      end
      if (go) begin
        sums <= s1_last ? '0 : sums_next;
      end
    end
  end

endmodule

[rtl/tlla_argmax.sv]
module tlla_argmax #(
  parameter int MAX_HYP = tlla_pkg::MAX_HYP_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic snap_valid,
  input  logic [MAX_HYP:0][tlla_pkg::SUM_W-1:0] snap_sums,
  output logic snap_ready,
  output logic res_valid,
  input  logic res_stall,
  output logic [$clog2(MAX_HYP+1)-1:0] best_length,
  output logic signed [tlla_pkg::SUM_W-1:0] best_score
);
  import tlla_pkg::*;

  localparam int HYP_COUNT   = MAX_HYP + 1;
  localparam int LEN_W       = $clog2(HYP_COUNT);
  localparam int GROUP_COUNT = (HYP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_COUNT   = GROUP_COUNT * GROUP_SIZE;

  logic a_valid;
  logic [HYP_COUNT-1:0][SUM_W-1:0] a_sums;
  logic b_valid;
  logic signed [SUM_W-1:0] b_score [GROUP_COUNT];
  logic [LEN_W-1:0]        b_idx   [GROUP_COUNT];

  logic signed [SUM_W-1:0] pad_sums  [PAD_COUNT];
  logic signed [SUM_W-1:0] grp_score [GROUP_COUNT];
  logic [LEN_W-1:0]        grp_idx   [GROUP_COUNT];
  logic signed [SUM_W-1:0] fin_score;
  logic [LEN_W-1:0]        fin_idx;
  logic c_ready;
  logic b_free;
  logic a_free;

  // Pad the last group with the minimum, which never wins a strict compare
  for (genvar i = 0; i < PAD_COUNT; i++) begin : g_pad
    if (i < HYP_COUNT) begin : g_real
      assign pad_sums[i] = $signed(a_sums[i]);
    end else begin : g_fill
      assign pad_sums[i] = SUM_MIN;
    end
  end

  // Scan each group in index order, keep the first maximum
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_score[g] = pad_sums[g*GROUP_SIZE];
      grp_idx[g]   = LEN_W'(g*GROUP_SIZE);
      for (int j = 1; j < GROUP_SIZE; j++) begin
        if (pad_sums[g*GROUP_SIZE+j] > grp_score[g]) begin
          grp_score[g] = pad_sums[g*GROUP_SIZE+j];
          grp_idx[g]   = LEN_W'(g*GROUP_SIZE+j);
        end
      end
    end
  end

  // Scan the group winners in order
  always_comb begin
    fin_score = b_score[0];
    fin_idx   = b_idx[0];
    for (int g = 1; g < GROUP_COUNT; g++) begin
      if (b_score[g] > fin_score) begin
        fin_score = b_score[g];
        fin_idx   = b_idx[g];
      end
    end
  end

  // Each stage moves when the next one is empty or moving
  always_comb begin
    c_ready    = !res_valid || !res_stall;
    b_free     = !b_valid || c_ready;
    a_free     = !a_valid || b_free;
    snap_ready = a_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= snap_valid;
        if (snap_valid) begin
          a_sums <= snap_sums;
        end
      end
      if (b_free) begin
        b_valid <= a_valid;
        if (a_valid) begin
          b_score <= grp_score;
          b_idx   <= grp_idx;
        end
      end
      if (c_ready) begin
        res_valid <= b_valid;
        if (b_valid) begin
          best_length <= fin_idx;
          best_score  <= fin_score;
        end
      end
    end
  end

endmodule

[rtl/table_loglikelihood_argmax_unit.sv]
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------------------
// request   | in        | req_valid / req_stall  | kind base obs_len hypothesis entry_value last
// result    | out       | res_valid / res_stall  | best_length best_score
//
// One request is taken per cycle while req_stall is low, table writes and
// observations alike; the single-port table (one lane write or one row read
// per cycle) and the accumulate loop set that rate.
// A last observation moves through the accumulate, a, b and result registers in turn.
// Reset clears the sums and the pipeline; the table is not cleared and must
// be written before it is read, so requests are taken from the first cycle.
// A waiting result stalls nothing until stages a and b are full and a later last
// observation needs its snapshot slot.
module table_loglikelihood_argmax_unit #(
  parameter int MAX_HYP       = tlla_pkg::MAX_HYP_DEF,
  parameter int OBS_LEN_COUNT = tlla_pkg::OBS_LEN_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  logic kind,
  input  logic [tlla_pkg::BASE_W-1:0] base,
  input  logic [tlla_pkg::OBS_W-1:0] obs_len,
  input  logic [tlla_pkg::HYP_IN_W-1:0] hypothesis,
  input  logic signed [tlla_pkg::ENTRY_W-1:0] entry_value,
  input  logic last,
  output logic res_valid,
  input  logic res_stall,
  output logic [$clog2(MAX_HYP+1)-1:0] best_length,
  output logic signed [tlla_pkg::SUM_W-1:0] best_score
);
  import tlla_pkg::*;

  localparam int HYP_COUNT = MAX_HYP + 1;
  localparam int LEN_W     = $clog2(HYP_COUNT);
  localparam int ADDR_W    = $clog2(BASE_COUNT * OBS_LEN_COUNT);

  logic accept;
  logic col_hit;
  logic hyp_hit;
  logic wr_en;
  logic rd_en;
  logic [ADDR_W-1:0] row_addr;
  logic [HYP_COUNT-1:0][ENTRY_W-1:0] rd_row;
  obs_req_t obs_req;
  logic acc_free;
  logic snap_valid;
  logic snap_ready;
  logic [HYP_COUNT-1:0][SUM_W-1:0] snap_sums;

  // Decode the request and drop writes outside the table
  always_comb begin
    req_stall = !acc_free;
    accept    = req_valid && !req_stall;
    col_hit   = 32'(obs_len) < OBS_LEN_COUNT;
    hyp_hit   = 32'(hypothesis) <= MAX_HYP;
    row_addr  = ADDR_W'(ADDR_W'(base) * ADDR_W'(OBS_LEN_COUNT) + ADDR_W'(obs_len));
    wr_en     = accept && (kind == KIND_WRITE) && col_hit && hyp_hit;
    rd_en     = accept && (kind == KIND_OBS);
    obs_req.start = rd_en;
    obs_req.last  = last;
    obs_req.hit   = col_hit;
  end

  tlla_table_mem #(
    .MAX_HYP       (MAX_HYP),
    .OBS_LEN_COUNT (OBS_LEN_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_addr),
    .wr_lane (LEN_W'(hypothesis)),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (row_addr),
    .rd_row  (rd_row)
  );

  tlla_accum #(
    .MAX_HYP (MAX_HYP)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .req        (obs_req),
    .row        (rd_row),
    .snap_ready (snap_ready),
    .free       (acc_free),
    .snap_valid (snap_valid),
    .snap_sums  (snap_sums)
  );

  tlla_argmax #(
    .MAX_HYP (MAX_HYP)
  ) u_argmax (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_sums   (snap_sums),
    .snap_ready  (snap_ready),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .best_length (best_length),
    .best_score  (best_score)
  );

  // A last observation blocked at the snapshot slot holds off new requests
  assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !snap_ready) |-> req_stall)
    else $error("request taken while snapshot is blocked");

  // A taken last observation reaches the snapshot point next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_OBS) && last) |=> snap_valid)
    else $error("last observation lost before snapshot");

  // A table write never produces a snapshot
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_WRITE)) |=> !snap_valid)
    else $error("table write produced a snapshot");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlla_pkg::*;

  localparam int HYP_COUNT   = MAX_HYP_DEF + 1;
  localparam int LEN_W       = $clog2(HYP_COUNT);
  localparam int ITEM_TARGET = 1050;
  localparam int SAT_RUN     = 260;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 12;
  localparam int CALM_FROM   = 300;
  localparam int CALM_TO     = 700;

  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  // Value flavors for a freshly written column
  typedef enum int {FILL_MIXED, FILL_TOP, FILL_EXTREME} fill_t;

  typedef struct packed {
    logic                       kind;
    logic [BASE_W-1:0]          base;
    logic [OBS_W-1:0]           obs_len;
    logic [HYP_IN_W-1:0]        hypothesis;
    logic signed [ENTRY_W-1:0]  entry_value;
    logic                       last;
  } lik_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]         best_length;
    logic signed [SUM_W-1:0]  best_score;
  } lik_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic kind = KIND_WRITE;
  logic [BASE_W-1:0] base = '0;
  logic [OBS_W-1:0] obs_len = '0;
  logic [HYP_IN_W-1:0] hypothesis = '0;
  logic signed [ENTRY_W-1:0] entry_value = '0;
  logic last = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [LEN_W-1:0] best_length;
  logic signed [SUM_W-1:0] best_score;

  // Predictor state
  logic signed [ENTRY_W-1:0] ll_entries [BASE_COUNT][HYP_COUNT][OBS_LEN_COUNT_DEF];
  logic signed [SUM_W-1:0]   length_sums [HYP_COUNT];

  lik_req_t    pending_reqs[$];
  lik_result_t pending_estimates[$];
  lik_req_t    cur_req;

  // Stimulus bookkeeping: columns whose 17 entries have all been written
  logic [BASE_W+OBS_W-1:0] ready_cols[$];
  int useful_items = 0;
  int fail_count = 0;
  int cycle_count = 0;

  table_loglikelihood_argmax_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .base        (base),
    .obs_len     (obs_len),
    .hypothesis  (hypothesis),
    .entry_value (entry_value),
    .last        (last),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .best_length (best_length),
    .best_score  (best_score)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Random gaps, none inside the calm window
  function automatic bit take_break();
    if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  // Fold one accepted request into the table and sums
  function automatic void absorb_request(lik_req_t r);
    longint acc;
    int best;
    lik_result_t res;
    if (r.kind == KIND_WRITE) begin
      if (r.hypothesis <= MAX_HYP_DEF && r.obs_len < OBS_LEN_COUNT_DEF)
        ll_entries[r.base][r.hypothesis][r.obs_len] = r.entry_value;
      return;
    end
    if (r.obs_len < OBS_LEN_COUNT_DEF) begin
      for (int h = 0; h < HYP_COUNT; h++) begin
        acc = longint'(length_sums[h]) + longint'(ll_entries[r.base][h][r.obs_len]);
        if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
        if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
        length_sums[h] = SUM_W'(acc);
      end
    end
    if (r.last) begin
      best = 0;
      for (int h = 1; h < HYP_COUNT; h++)
        if (length_sums[h] > length_sums[best]) best = h;
      res.best_length = LEN_W'(best);
      res.best_score  = length_sums[best];
      pending_estimates.push_back(res);
      for (int h = 0; h < HYP_COUNT; h++) length_sums[h] = '0;
    end
  endfunction

  function automatic logic signed [ENTRY_W-1:0] pick_entry();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 10) return ENTRY_MAX;
    if (r < 20) return ENTRY_MIN;
    if (r < 45) begin
      v = $urandom_range(6);
      v = v - 3;
      return ENTRY_W'(v);
    end
    return ENTRY_W'($urandom());
  endfunction

  task automatic push_write(int b, int h, int col, logic signed [ENTRY_W-1:0] v, bit lst);
    lik_req_t r;
    r.kind = KIND_WRITE;
    r.base = BASE_W'(b);
    r.obs_len = OBS_W'(col);
    r.hypothesis = HYP_IN_W'(h);
    r.entry_value = v;
    r.last = lst;
    pending_reqs.push_back(r);
    if (h <= MAX_HYP_DEF) useful_items++;
  endtask

  task automatic push_obs(logic [BASE_W+OBS_W-1:0] where, bit lst);
    lik_req_t r;
    r.kind = KIND_OBS;
    {r.base, r.obs_len} = where;
    r.hypothesis = HYP_IN_W'($urandom());
    r.entry_value = ENTRY_W'($urandom());
    r.last = lst;
    pending_reqs.push_back(r);
    useful_items++;
  endtask

  // Write all hypotheses of one column, then mark it readable
  task automatic write_column(int b, int col, fill_t fill);
    logic signed [ENTRY_W-1:0] v;
    logic [BASE_W+OBS_W-1:0] key;
    for (int h = 0; h < HYP_COUNT; h++) begin
      case (fill)
        FILL_TOP:     v = ENTRY_MAX;
        FILL_EXTREME: v = (h == 0) ? ENTRY_MIN : (h == MAX_HYP_DEF) ? ENTRY_MAX :
                          ($urandom_range(1) ? ENTRY_MAX : ENTRY_MIN);
        default:      v = pick_entry();
      endcase
      push_write(b, h, col, v, $urandom_range(9) == 0);
    end
    key = {BASE_W'(b), OBS_W'(col)};
    foreach (ready_cols[i]) if (ready_cols[i] == key) return;
    ready_cols.push_back(key);
  endtask

  function automatic logic [BASE_W+OBS_W-1:0] any_ready();
    return ready_cols[$urandom_range(ready_cols.size() - 1)];
  endfunction

  // Build the request list: directed cases, a saturating set, then random traffic
  initial begin
    int sel;
    int len;
    logic [BASE_W+OBS_W-1:0] where;

    // Column of equal maxima: tie goes to hypothesis zero
    write_column(BASE_COUNT - 1, OBS_LEN_COUNT_DEF - 1, FILL_TOP);
    push_obs({2'd3, 5'd31}, 1'b1);
    // Last flag on a write yields nothing; out-of-range hypothesis is dropped
    push_write(BASE_COUNT - 1, 0, OBS_LEN_COUNT_DEF - 1, ENTRY_MIN, 1'b1);
    push_write(BASE_COUNT - 1, 31, OBS_LEN_COUNT_DEF - 1, ENTRY_MIN, 1'b0);
    // Hypothesis zero now lowest: tie among the rest goes to one
    push_obs({2'd3, 5'd31}, 1'b1);

    // Long set driving sums into both clamps
    write_column(2, 17, FILL_EXTREME);
    for (int i = 0; i < SAT_RUN; i++) push_obs({2'd2, 5'd17}, i == SAT_RUN - 1);

    while (useful_items < ITEM_TARGET) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        write_column($urandom_range(BASE_COUNT - 1), $urandom_range(OBS_LEN_COUNT_DEF - 1),
                     FILL_MIXED);
      end else if (sel < 16) begin
        where = any_ready();
        push_write(where[OBS_W +: BASE_W], $urandom_range(MAX_HYP_DEF), where[OBS_W-1:0],
                   pick_entry(), $urandom_range(1));
      end else if (sel < 19) begin
        push_write($urandom_range(BASE_COUNT - 1), $urandom_range(31, MAX_HYP_DEF + 1),
                   $urandom_range(OBS_LEN_COUNT_DEF - 1), ENTRY_W'($urandom()),
                   $urandom_range(1));
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) push_obs(any_ready(), i == len - 1);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Request driver: predict on acceptance, then advance or hold
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) absorb_request(cur_req);
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          cur_req = pending_reqs.pop_front();
          req_valid   <= 1'b1;
          kind        <= cur_req.kind;
          base        <= cur_req.base;
          obs_len     <= cur_req.obs_len;
          hypothesis  <= cur_req.hypothesis;
          entry_value <= cur_req.entry_value;
          last        <= cur_req.last;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest estimate, stall at random
  always @(posedge clk) begin
    lik_result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result, expected none, got length %0d score %0d",
                   $time, best_length, best_score);
          fail_count++;
        end else begin
          want = pending_estimates.pop_front();
          if (best_length !== want.best_length) begin
            $display("%0t: best_length expected %0d got %0d",
                     $time, want.best_length, best_length);
            fail_count++;
          end
          if (best_score !== want.best_score) begin
            $display("%0t: best_score expected %0d got %0d",
                     $time, want.best_score, best_score);
            fail_count++;
          end
        end
      end
      res_stall <= take_break();
    end
  end

endmodule
